// ===== design/rhwp_pkg.sv =====
package rhwp_pkg;

    localparam int WORD_W   = 32;
    localparam int FIELD_W  = 5;
    localparam int STATUS_W = 2;
    localparam int MDATA_W  = 40;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_TYPE,
        PH_RPCVER,
        PH_PROG,
        PH_PROGVER,
        PH_PROC,
        PH_CFLAV,
        PH_CLEN,
        PH_VFLAV,
        PH_VLEN,
        PH_RSTAT,
        PH_RVFLAV,
        PH_RVLEN,
        PH_ACCEPT,
        PH_REJECT,
        PH_LOW,
        PH_HIGH,
        PH_AUTHERR
    } phase_t;

    localparam logic [FIELD_W-1:0] FC_XID      = 5'd0;
    localparam logic [FIELD_W-1:0] FC_TYPE     = 5'd1;
    localparam logic [FIELD_W-1:0] FC_RPCVER   = 5'd2;
    localparam logic [FIELD_W-1:0] FC_PROG     = 5'd3;
    localparam logic [FIELD_W-1:0] FC_PROGVER  = 5'd4;
    localparam logic [FIELD_W-1:0] FC_PROC     = 5'd5;
    localparam logic [FIELD_W-1:0] FC_CFLAV    = 5'd6;
    localparam logic [FIELD_W-1:0] FC_CLEN     = 5'd7;
    localparam logic [FIELD_W-1:0] FC_VFLAV    = 5'd8;
    localparam logic [FIELD_W-1:0] FC_VLEN     = 5'd9;
    localparam logic [FIELD_W-1:0] FC_RSTAT    = 5'd10;
    localparam logic [FIELD_W-1:0] FC_ACCEPT   = 5'd11;
    localparam logic [FIELD_W-1:0] FC_REJECT   = 5'd12;
    localparam logic [FIELD_W-1:0] FC_LOW      = 5'd13;
    localparam logic [FIELD_W-1:0] FC_HIGH     = 5'd14;
    localparam logic [FIELD_W-1:0] FC_AUTHERR  = 5'd15;
    localparam logic [FIELD_W-1:0] FC_IGNORED  = 5'd16;

    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    localparam logic [WORD_W-1:0] MSG_CALL       = 32'd0;
    localparam logic [WORD_W-1:0] MSG_REPLY      = 32'd1;
    localparam logic [WORD_W-1:0] RPC_VERSION    = 32'd2;
    localparam logic [WORD_W-1:0] AUTH_NONE      = 32'd0;
    localparam logic [WORD_W-1:0] RS_ACCEPTED    = 32'd0;
    localparam logic [WORD_W-1:0] RS_DENIED      = 32'd1;
    localparam logic [WORD_W-1:0] AS_PROG_MISM   = 32'd2;
    localparam logic [WORD_W-1:0] AS_SYSTEM_ERR  = 32'd5;
    localparam logic [WORD_W-1:0] RJ_RPC_MISM    = 32'd0;
    localparam logic [WORD_W-1:0] RJ_AUTH_ERROR  = 32'd1;

    typedef struct packed {
        phase_t                next_phase;
        logic [FIELD_W-1:0]    field_code;
        logic [STATUS_W-1:0]   status;
    } decode_t;

endpackage

// ===== design/rpc_header_word_parser_unit.sv =====
// Parses an ONC RPC message header one 32-bit XDR word per item. An item with
// s_tuser set is the xid of a new header; each later word comes out tagged
// with the header field it holds and a status of in progress, complete,
// invalid or ignored. Calls must carry RPC version 2 and AUTH_NONE credential
// and verifier of zero length. The block takes one item per cycle while the
// output is not stalled, and each decoded item shows up in the cycle after it
// is accepted, held in the single result register until it is taken.
module rpc_header_word_parser_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // word[31:0]
    input  logic [rhwp_pkg::WORD_W-1:0]   s_tdata,
    // start_req[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // field_code[4:0], value[36:5], status[38:37], zero[39]
    output logic [rhwp_pkg::MDATA_W-1:0]  m_tdata
);
    import rhwp_pkg::*;

    localparam int PAD_W = MDATA_W - FIELD_W - WORD_W - STATUS_W;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [MDATA_W-1:0]    out_data_reg;
    logic [MDATA_W-1:0]    out_data_next;
    logic                  in_fire;
    decode_t               dec;

    rhwp_decode u_decode (
        .phase     (phase_reg),
        .word      (s_tdata),
        .start_req (s_tuser),
        .dec       (dec)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (in_fire) begin
            phase_next     = dec.next_phase;
            out_valid_next = 1'b1;
            out_data_next  = {{PAD_W{1'b0}}, dec.status, s_tdata, dec.field_code};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== design/rhwp_decode.sv =====
module rhwp_decode (
    input  rhwp_pkg::phase_t              phase,
    input  logic [rhwp_pkg::WORD_W-1:0]   word,
    input  logic                          start_req,
    output rhwp_pkg::decode_t             dec
);
    import rhwp_pkg::*;

    logic is_zero;

    assign is_zero = (word == '0);

    always_comb begin
        dec.next_phase = PH_IDLE;
        dec.field_code = FC_IGNORED;
        dec.status     = ST_BUSY;
        if (start_req) begin
            dec.field_code = FC_XID;
            dec.next_phase = PH_TYPE;
        end else begin
            case (phase)
                PH_TYPE: begin
                    dec.field_code = FC_TYPE;
                    if (word == MSG_CALL) dec.next_phase = PH_RPCVER;
                    else if (word == MSG_REPLY) dec.next_phase = PH_RSTAT;
                    else dec.status = ST_BAD;
                end
                PH_RPCVER: begin
                    dec.field_code = FC_RPCVER;
                    if (word == RPC_VERSION) dec.next_phase = PH_PROG;
                    else dec.status = ST_BAD;
                end
                PH_PROG: begin
                    dec.field_code = FC_PROG;
                    dec.next_phase = PH_PROGVER;
                end
                PH_PROGVER: begin
                    dec.field_code = FC_PROGVER;
                    dec.next_phase = PH_PROC;
                end
                PH_PROC: begin
                    dec.field_code = FC_PROC;
                    dec.next_phase = PH_CFLAV;
                end
                PH_CFLAV: begin
                    dec.field_code = FC_CFLAV;
                    if (word == AUTH_NONE) dec.next_phase = PH_CLEN;
                    else dec.status = ST_BAD;
                end
                PH_CLEN: begin
                    dec.field_code = FC_CLEN;
                    if (is_zero) dec.next_phase = PH_VFLAV;
                    else dec.status = ST_BAD;
                end
                PH_VFLAV: begin
                    dec.field_code = FC_VFLAV;
                    if (word == AUTH_NONE) dec.next_phase = PH_VLEN;
                    else dec.status = ST_BAD;
                end
                PH_VLEN: begin
                    dec.field_code = FC_VLEN;
                    dec.status     = is_zero ? ST_DONE : ST_BAD;
                end
                PH_RSTAT: begin
                    dec.field_code = FC_RSTAT;
                    if (word == RS_ACCEPTED) dec.next_phase = PH_RVFLAV;
                    else if (word == RS_DENIED) dec.next_phase = PH_REJECT;
                    else dec.status = ST_BAD;
                end
                PH_RVFLAV: begin
                    dec.field_code = FC_VFLAV;
                    if (word == AUTH_NONE) dec.next_phase = PH_RVLEN;
                    else dec.status = ST_BAD;
                end
                PH_RVLEN: begin
                    dec.field_code = FC_VLEN;
                    if (is_zero) dec.next_phase = PH_ACCEPT;
                    else dec.status = ST_BAD;
                end
                PH_ACCEPT: begin
                    dec.field_code = FC_ACCEPT;
                    if (word == AS_PROG_MISM) dec.next_phase = PH_LOW;
                    else if (word <= AS_SYSTEM_ERR) dec.status = ST_DONE;
                    else dec.status = ST_BAD;
                end
                PH_REJECT: begin
                    dec.field_code = FC_REJECT;
                    if (word == RJ_RPC_MISM) dec.next_phase = PH_LOW;
                    else if (word == RJ_AUTH_ERROR) dec.next_phase = PH_AUTHERR;
                    else dec.status = ST_BAD;
                end
                PH_LOW: begin
                    dec.field_code = FC_LOW;
                    dec.next_phase = PH_HIGH;
                end
                PH_HIGH: begin
                    dec.field_code = FC_HIGH;
                    dec.status     = ST_DONE;
                end
                PH_AUTHERR: begin
                    dec.field_code = FC_AUTHERR;
                    dec.status     = ST_DONE;
                end
                default: begin
                    dec.field_code = FC_IGNORED;
                    dec.status     = ST_IGNORED;
                end
            endcase
        end
    end

endmodule

// ===== design/rhwp_checker.sv =====
module rhwp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [rhwp_pkg::WORD_W-1:0]   s_tdata,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rhwp_pkg::MDATA_W-1:0]  m_tdata
);
    import rhwp_pkg::*;

    logic in_fire;

    assign in_fire = s_tvalid && s_tready;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_tvalid && m_tdata[36:5] == $past(s_tdata))
        else $error("accepted item did not produce its result");

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_tuser |=> m_tdata[4:0] == FC_XID && m_tdata[38:37] == ST_BUSY)
        else $error("start word not reported as xid in progress");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rpc_header_word_parser_unit rhwp_checker u_rhwp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
